// ===== rtl/scc_pkg.sv =====
// scc_pkg: shared types and constants for the single-cube containment block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package scc_pkg;

  localparam int CUBE_W        = 32;
  localparam int DEF_MAX_CUBES = 64;
  localparam int DEF_NUM_VARS  = 16;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    S_LOAD,
    S_OUTER,
    S_AWAIT,
    S_SCAN,
    S_EMIT,
    S_EGET,
    S_LAST
  } scc_state_t;

endpackage

`default_nettype wire

// ===== rtl/scc_if.sv =====
// scc_if: valid/ready channel interfaces for cube words in and kept cubes out
// depends on scc_pkg for the cube width
`default_nettype none

interface scc_in_if import scc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CUBE_W-1:0] cube_bits;
  logic              list_end;

  modport source (output valid, output cube_bits, output list_end, input ready);
  modport sink   (input valid, input cube_bits, input list_end, output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CUBE_W-1:0] kept_cube;
  logic              final_cube;
  logic              overflowed;

  modport source (output valid, output kept_cube, output final_cube, output overflowed,
                  input ready);
  modport sink   (input valid, input kept_cube, input final_cube, input overflowed,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/single_cube_containment.sv =====
// single_cube_containment: collects a cube list, removes cubes contained in
// other live cubes and streams the survivors; uses scc_pkg, scc_if, scc_ram
//
//   channel | direction | fields                             | handshake
//   in_ch   | in        | cube_bits, list_end                | valid/ready
//   out_ch  | out       | kept_cube, final_cube, overflowed  | valid/ready
//
// cube words are accepted while loading; the list end word starts the
// containment pass, in which the single comparator walks the cube RAM one
// entry a cycle per live container.
// survivors leave through an output register; the pass stalls while it is full.
// reset is synchronous active low and clears counters and valid flags; the removed
// mark sits beside each cube in the RAM and is cleared when the cube is stored.
`default_nettype none

module single_cube_containment import scc_pkg::*; #(
  parameter int MAX_CUBES = DEF_MAX_CUBES,
  parameter int NUM_VARS  = DEF_NUM_VARS
) (
  input  logic      clk,
  input  logic      rst_n,
  scc_in_if.sink    in_ch,
  scc_out_if.source out_ch
);

  localparam int ADDR_W = $clog2(MAX_CUBES);
  localparam int CNT_W  = $clog2(MAX_CUBES + 1);
  localparam int RAM_W  = CUBE_W + 1;
  localparam int MASK_W = 2 * ((NUM_VARS > 16) ? 16 : NUM_VARS);
  localparam logic [CUBE_W-1:0] CUBE_MASK = {CUBE_W{1'b1}} >> (CUBE_W - MASK_W);
  localparam logic [CNT_W-1:0]  CAP       = CNT_W'(MAX_CUBES);

  scc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r;
  logic                 ovf_r;
  logic [CNT_W-1:0]     i_r, j_r, k_r;
  logic [ADDR_W-1:0]    jd_r;
  logic                 pv_r;
  logic [CUBE_W-1:0]    a_r;
  logic [CUBE_W-1:0]    pend_r;
  logic                 pend_v_r;
  logic                 out_valid_r;
  logic [CUBE_W-1:0]    out_cube_r;
  logic                 out_final_r;
  logic                 out_ovf_r;

  logic                 accept;
  logic                 full;
  logic                 slot_free;
  logic                 i_done, j_done, k_done;
  logic [ADDR_W-1:0]    i_idx, j_idx, k_idx;
  logic                 covers;
  logic                 gone;
  logic                 strike;
  logic                 out_load;
  logic [CUBE_W-1:0]    rd_cube;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [RAM_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [RAM_W-1:0]     ram_rdata;

  assign accept    = in_ch.valid && in_ch.ready;
  assign full      = (cnt_r == CAP);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign i_done    = (i_r == cnt_r);
  assign j_done    = (j_r == cnt_r);
  assign k_done    = (k_r == cnt_r);
  assign i_idx     = i_r[ADDR_W-1:0];
  assign j_idx     = j_r[ADDR_W-1:0];
  assign k_idx     = k_r[ADDR_W-1:0];
  // top bit of a ram word marks the cube as removed
  assign rd_cube   = ram_rdata[CUBE_W-1:0];
  assign gone      = ram_rdata[CUBE_W];
  assign covers    = ((a_r & rd_cube) == rd_cube);
  // compare stage: container i removes a live cube it covers
  assign strike    = pv_r && (jd_r != i_idx) && !gone && covers;
  assign out_load  = ((state_r == S_EGET) && !gone && pend_v_r && slot_free) ||
                     ((state_r == S_LAST) && slot_free);

  scc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_CUBES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (accept && in_ch.list_end) state_nxt = S_OUTER;
      end
      S_OUTER: begin
        if (i_done) state_nxt = S_EMIT;
        else        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (gone) state_nxt = S_OUTER;
        else      state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (j_done && !pv_r) state_nxt = S_OUTER;
      end
      S_EMIT: begin
        if (k_done) state_nxt = S_LAST;
        else        state_nxt = S_EGET;
      end
      S_EGET: begin
        if (gone || !pend_v_r || slot_free) state_nxt = S_EMIT;
      end
      S_LAST: begin
        if (slot_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // ram and handshake controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[ADDR_W-1:0];
    ram_wdata = {1'b0, in_ch.cube_bits & CUBE_MASK};
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      S_LOAD: begin
        ram_we = accept && !full;
      end
      S_OUTER: begin
        ram_re    = !i_done;
        ram_raddr = i_idx;
      end
      S_SCAN: begin
        ram_re    = !j_done;
        ram_raddr = j_idx;
        ram_we    = strike;
        ram_waddr = jd_r;
        ram_wdata = {1'b1, rd_cube};
      end
      S_EMIT: begin
        ram_re    = !k_done;
        ram_raddr = k_idx;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign in_ch.ready       = (state_r == S_LOAD);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kept_cube  = out_cube_r;
  assign out_ch.final_cube = out_final_r;
  assign out_ch.overflowed = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      pv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (full) ovf_r <= 1'b1;
            else      cnt_r <= cnt_r + 1'b1;
            if (in_ch.list_end) i_r <= '0;
          end
        end
        S_OUTER: begin
          if (i_done) begin
            k_r      <= '0;
            pend_v_r <= 1'b0;
          end
        end
        S_AWAIT: begin
          if (gone) begin
            i_r <= i_r + 1'b1;
          end else begin
            a_r  <= rd_cube;
            j_r  <= '0;
            pv_r <= 1'b0;
          end
        end
        S_SCAN: begin
          pv_r <= !j_done;
          jd_r <= j_idx;
          if (!j_done) j_r <= j_r + 1'b1;
          if (j_done && !pv_r) i_r <= i_r + 1'b1;
        end
        S_EGET: begin
          if (gone) begin
            k_r <= k_r + 1'b1;
          end else if (!pend_v_r || slot_free) begin
            // hold one survivor back so the last one can be marked
            pend_r   <= rd_cube;
            pend_v_r <= 1'b1;
            k_r      <= k_r + 1'b1;
            if (pend_v_r) begin
              out_cube_r  <= pend_r;
              out_final_r <= 1'b0;
              out_ovf_r   <= ovf_r;
            end
          end
        end
        S_LAST: begin
          if (slot_free) begin
            out_cube_r  <= pend_r;
            out_final_r <= 1'b1;
            out_ovf_r   <= ovf_r;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            pend_v_r    <= 1'b0;
          end
        end
        default: begin
          pv_r <= 1'b0;
        end
      endcase
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP)
    else $error("stored count beyond capacity");

  a_container_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && ram_we) |-> (ram_waddr != i_idx))
    else $error("container cube removed during its own scan");

  a_pass_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && state_nxt == S_OUTER) |=> (cnt_r != '0))
    else $error("containment pass started on an empty list");

  a_last_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST) |-> pend_v_r)
    else $error("no survivor held back for the final word");

endmodule

`default_nettype wire

// ===== rtl/scc_ram.sv =====
// scc_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
